>>> sv/open_address_hash_table_assert.svh
// Assertion macros used by the hash table datapath (oaht_dp).
// Expects clk and arst_n in the scope of each use.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define OAHT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define OAHT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/oaht_pkg.sv
// Package for the open-address hash table: sizes, codes, hash constant and
// the command/status structs between controller and datapath. No dependencies.
package oaht_pkg;

	localparam int SLOTS      = 256;
	localparam int SLOT_BITS  = $clog2(SLOTS);
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = $clog2(SLOTS + 1);
	localparam int OP_BITS    = 2;
	localparam int STAT_BITS  = 2;
	localparam int TAG_BITS   = 2;
	localparam int LOAD_NUM   = 3;
	localparam int LOAD_DEN   = 4;
	localparam int LOAD_LIMIT = SLOTS * LOAD_NUM / LOAD_DEN;

	localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
	localparam int          HASH_SHIFT = 32;

	localparam logic [OP_BITS-1:0] OP_GET = 2'd0;
	localparam logic [OP_BITS-1:0] OP_SET = 2'd1;
	localparam logic [OP_BITS-1:0] OP_DEL = 2'd2;

	localparam logic [STAT_BITS-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_ABSENT = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd2;

	localparam logic [TAG_BITS-1:0] TAG_EMPTY = 2'd0;
	localparam logic [TAG_BITS-1:0] TAG_LIVE  = 2'd1;
	localparam logic [TAG_BITS-1:0] TAG_TOMB  = 2'd2;

	typedef struct packed {
		logic load;
		logic hash;
		logic home;
		logic step;
		logic examine;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic probe_done;
	} stat_t;

endpackage

>>> sv/oaht_req_if.sv
// Request channel of the hash table: valid/ready plus one operation.
// Depends on oaht_pkg.
interface oaht_req_if;
	import oaht_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_BITS-1:0]    opcode;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] write_value;

	modport source(output valid, opcode, lookup_key, write_value, input ready);
	modport sink(input valid, opcode, lookup_key, write_value, output ready);
endinterface

>>> sv/oaht_rsp_if.sv
// Response channel of the hash table: valid/ready plus one result.
// Depends on oaht_pkg.
interface oaht_rsp_if;
	import oaht_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STAT_BITS-1:0]  status;
	logic [VALUE_BITS-1:0] read_value;
	logic                  key_was_new;
	logic [COUNT_BITS-1:0] live_entries;

	modport source(output valid, status, read_value, key_was_new, live_entries, input ready);
	modport sink(input valid, status, read_value, key_was_new, live_entries, output ready);
endinterface

>>> sv/oaht_dp.sv
// Datapath of the hash table: hash, slot memory, probe walk, commit and
// result register. Depends on oaht_pkg and open_address_hash_table_assert.svh.
`include "open_address_hash_table_assert.svh"

module oaht_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  oaht_pkg::cmd_t                 cmd,
	output oaht_pkg::stat_t                stat,
	input  logic [oaht_pkg::OP_BITS-1:0]   opcode,
	input  logic [oaht_pkg::KEY_BITS-1:0]  lookup_key,
	input  logic [oaht_pkg::VALUE_BITS-1:0] write_value,
	output logic [oaht_pkg::STAT_BITS-1:0] status,
	output logic [oaht_pkg::VALUE_BITS-1:0] read_value,
	output logic                           key_was_new,
	output logic [oaht_pkg::COUNT_BITS-1:0] live_entries
);
	import oaht_pkg::*;

	localparam int WORD_BITS = TAG_BITS + KEY_BITS + VALUE_BITS;
	localparam int PROD_BITS = KEY_BITS + HASH_SHIFT;
	localparam logic [HASH_SHIFT-1:0] HASH_LO = HASH_MUL[HASH_SHIFT-1:0];
	localparam logic [SLOT_BITS-1:0]  HASH_HI = HASH_MUL[HASH_SHIFT +: SLOT_BITS];

	typedef enum logic [1:0] {FND_NONE, FND_EMPTY, FND_LIVE, FND_TOMB} found_t;

	logic [OP_BITS-1:0]    op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [PROD_BITS-1:0]  prod_s1;
	logic [SLOT_BITS-1:0]  hi_s1;

	logic [WORD_BITS-1:0]  mem [SLOTS];
	logic [SLOTS-1:0]      vld_q;
	logic [WORD_BITS-1:0]  word_s2;
	logic                  vld_s2;

	logic [SLOT_BITS-1:0]  addr_q;
	logic [SLOT_BITS-1:0]  chk_q;
	logic [SLOT_BITS-1:0]  n_q;
	logic                  tomb_seen_q;
	logic [SLOT_BITS-1:0]  tomb_idx_q;
	found_t                fnd_q;
	logic [SLOT_BITS-1:0]  fnd_idx_q;
	logic [VALUE_BITS-1:0] fnd_val_q;

	logic [COUNT_BITS-1:0] occ_q;
	logic [COUNT_BITS-1:0] live_q;
	logic [STAT_BITS-1:0]  status_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  key_was_new_q;

	logic [TAG_BITS-1:0]   tag_w;
	logic [KEY_BITS-1:0]   key_w;
	logic [VALUE_BITS-1:0] val_w;
	logic                  slot_free;
	logic                  is_tomb;
	logic                  is_hit;
	logic                  is_last;

	logic                  mem_we;
	logic [WORD_BITS-1:0]  wr_word;
	logic [STAT_BITS-1:0]  c_status;
	logic [VALUE_BITS-1:0] c_read;
	logic                  c_new;
	logic                  occ_inc;
	logic                  live_inc;
	logic                  live_dec;

	assign tag_w     = vld_s2 ? word_s2[WORD_BITS-1 -: TAG_BITS] : TAG_EMPTY;
	assign key_w     = word_s2[VALUE_BITS +: KEY_BITS];
	assign val_w     = word_s2[VALUE_BITS-1:0];
	assign slot_free = (tag_w == TAG_EMPTY);
	assign is_tomb   = (tag_w == TAG_TOMB);
	assign is_hit    = (tag_w == TAG_LIVE) && (key_w == key_q);
	assign is_last   = (n_q == {SLOT_BITS{1'b1}});

	assign stat.probe_done = slot_free || is_hit || is_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= lookup_key;
			val_q <= write_value;
		end
		if (cmd.hash) begin
			prod_s1 <= key_q * HASH_LO;
			hi_s1   <= SLOT_BITS'(key_q[SLOT_BITS-1:0] * HASH_HI);
		end
		if (cmd.step) begin
			word_s2 <= mem[addr_q];
			vld_s2  <= vld_q[addr_q];
		end
		if (mem_we) begin
			mem[fnd_idx_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			addr_q      <= '0;
			chk_q       <= '0;
			n_q         <= '0;
			tomb_seen_q <= 1'b0;
			tomb_idx_q  <= '0;
			fnd_q       <= FND_NONE;
			fnd_idx_q   <= '0;
			fnd_val_q   <= '0;
			occ_q       <= '0;
			live_q      <= '0;
		end else begin
			if (cmd.home) begin
				addr_q      <= prod_s1[HASH_SHIFT +: SLOT_BITS] + hi_s1;
				n_q         <= '0;
				tomb_seen_q <= 1'b0;
			end
			if (cmd.step) begin
				addr_q <= addr_q + 1'b1;
				chk_q  <= addr_q;
			end
			if (cmd.examine) begin
				n_q <= n_q + 1'b1;
				if (is_tomb && !tomb_seen_q) begin
					tomb_seen_q <= 1'b1;
					tomb_idx_q  <= chk_q;
				end
				if (is_hit) begin
					fnd_q     <= FND_LIVE;
					fnd_idx_q <= chk_q;
					fnd_val_q <= val_w;
				end else if (tomb_seen_q) begin
					fnd_q     <= FND_TOMB;
					fnd_idx_q <= tomb_idx_q;
				end else if (slot_free) begin
					fnd_q     <= FND_EMPTY;
					fnd_idx_q <= chk_q;
				end else if (is_tomb) begin
					fnd_q     <= FND_TOMB;
					fnd_idx_q <= chk_q;
				end else begin
					fnd_q <= FND_NONE;
				end
			end
			if (mem_we) begin
				vld_q[fnd_idx_q] <= 1'b1;
			end
			if (cmd.commit) begin
				if (occ_inc) begin
					occ_q <= occ_q + 1'b1;
				end
				if (live_inc) begin
					live_q <= live_q + 1'b1;
				end else if (live_dec) begin
					live_q <= live_q - 1'b1;
				end
			end
		end
	end

	always_comb begin
		c_status = ST_ABSENT;
		c_read   = '0;
		c_new    = 1'b0;
		occ_inc  = 1'b0;
		live_inc = 1'b0;
		live_dec = 1'b0;
		mem_we   = 1'b0;
		wr_word  = {TAG_LIVE, key_q, val_q};
		case (op_q)
			OP_GET: begin
				if (fnd_q == FND_LIVE) begin
					c_status = ST_DONE;
					c_read   = fnd_val_q;
				end
			end
			OP_SET: begin
				case (fnd_q)
					FND_LIVE: begin
						c_status = ST_DONE;
						mem_we   = 1'b1;
					end
					FND_TOMB: begin
						c_status = ST_DONE;
						c_new    = 1'b1;
						live_inc = 1'b1;
						mem_we   = 1'b1;
					end
					FND_EMPTY: begin
						if (occ_q >= COUNT_BITS'(LOAD_LIMIT)) begin
							c_status = ST_FULL;
						end else begin
							c_status = ST_DONE;
							c_new    = 1'b1;
							occ_inc  = 1'b1;
							live_inc = 1'b1;
							mem_we   = 1'b1;
						end
					end
					default: c_status = ST_FULL;
				endcase
			end
			OP_DEL: begin
				if (fnd_q == FND_LIVE) begin
					c_status = ST_DONE;
					wr_word  = {TAG_TOMB, key_q, {VALUE_BITS{1'b0}}};
					mem_we   = 1'b1;
					live_dec = (live_q != '0);
				end
			end
			default: c_status = ST_ABSENT;
		endcase
		mem_we = mem_we && cmd.commit;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q      <= c_status;
			read_value_q  <= c_read;
			key_was_new_q <= c_new;
		end
	end

	assign status       = status_q;
	assign read_value   = read_value_q;
	assign key_was_new  = key_was_new_q;
	assign live_entries = live_q;

	`OAHT_ASSERT_ALWAYS(a_live_le_occ, live_q <= occ_q, "live count above occupied count")
	`OAHT_ASSERT_ALWAYS(a_occ_limit, occ_q <= COUNT_BITS'(LOAD_LIMIT), "occupancy above load limit")
	`OAHT_ASSERT_NEXT(a_counts_hold, !cmd.commit, $stable(occ_q) && $stable(live_q), "counts moved")
	`OAHT_ASSERT_IMPL(a_write_found, mem_we, fnd_q != FND_NONE, "slot write without a probe result")

endmodule

>>> sv/oaht_ctrl.sv
// Controller of the hash table: sequences hash, probe walk and commit, and
// owns the handshakes of both channels. Depends on oaht_pkg.
module oaht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output oaht_pkg::cmd_t  cmd,
	input  oaht_pkg::stat_t stat
);
	import oaht_pkg::*;

	typedef enum logic [2:0] {IDLE, HASH, HOME, FETCH, PROBE, COMMIT} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_commit;

	assign can_commit = !out_valid_q || out_ready;
	assign in_ready   = (state_q == IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd.load    = (state_q == IDLE) && in_valid;
		cmd.hash    = (state_q == HASH);
		cmd.home    = (state_q == HOME);
		cmd.step    = (state_q == FETCH) || (state_q == PROBE);
		cmd.examine = (state_q == PROBE);
		cmd.commit  = (state_q == COMMIT) && can_commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) state_q <= HASH;
				end
				HASH:  state_q <= HOME;
				HOME:  state_q <= FETCH;
				FETCH: state_q <= PROBE;
				PROBE: begin
					if (stat.probe_done) state_q <= COMMIT;
				end
				COMMIT: begin
					if (can_commit) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> sv/open_address_hash_table.sv
// Top level of the open-address hash table (linear probing, tombstones).
// Depends on oaht_pkg, oaht_req_if, oaht_rsp_if, oaht_ctrl and oaht_dp.
//
//   channel  dir  payload                                        transaction
//   req      in   opcode, lookup_key, write_value                one operation
//   rsp      out  status, read_value, key_was_new, live_entries  one result
//
// After acceptance an operation passes HASH, HOME, FETCH, PROBE and COMMIT,
// PROBE walking k slots (1 to 193, at least a quarter of the slots stays
// empty); the single read port of the slot memory sets one slot per cycle.
// The next request is taken in the cycle after the result is registered.
// Reset empties the table at once (per-slot valid bits); a stalled rsp holds
// the following operation at its commit.
module open_address_hash_table (
	input logic        clk,
	input logic        arst_n,
	oaht_req_if.sink   req,
	oaht_rsp_if.source rsp
);
	import oaht_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	oaht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	oaht_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (req.opcode),
		.lookup_key   (req.lookup_key),
		.write_value  (req.write_value),
		.status       (rsp.status),
		.read_value   (rsp.read_value),
		.key_was_new  (rsp.key_was_new),
		.live_entries (rsp.live_entries)
	);

endmodule
